FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the order book feature engine; obfe_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define OBFE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("obfe assertion failed");

// Checks that a trigger implies a consequence in the same cycle.
`define OBFE_ASSERT_IMPLIES(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cons)) \
        else $error("obfe assertion failed");

`endif

FILE: rtl/obfe_pkg.sv
// Types and constants shared by the order book feature engine modules.
`timescale 1ns / 1ps
package obfe_pkg;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_TAU = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_TAU   = 8'd1;
    localparam logic [31:0] BURST_TAU_RESET = 32'd200000;
    localparam logic [31:0] VOL_TAU_RESET   = 32'd2000000;

    // Delta action codes.
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_ADD_A = 2'd1;
    localparam logic [1:0] ACT_ADD_B = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 64;

    // One command from the parser to the execution side.
    typedef struct packed {
        logic        do_delta;
        logic        do_emit;
        logic [31:0] price;
        logic [31:0] qty;
        logic [15:0] level;
        logic        side;
        logic [1:0]  action;
        logic [63:0] timestamp;
    } cmd_t;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: rtl/obfe_front.sv
// Beat parser: tracks the packet phase and turns beats into commands.
`timescale 1ns / 1ps
module obfe_front #(
    parameter int MAX_DELTAS = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic             queue_full,
    output logic             push,
    output obfe_pkg::cmd_t   push_cmd
);

    localparam int REM_W = $clog2(MAX_DELTAS + 1);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_HDR2  = 3'd2;
    localparam logic [2:0] PH_HDR3  = 3'd3;
    localparam logic [2:0] PH_DELTA_A = 3'd4;
    localparam logic [2:0] PH_DELTA_B = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [63:0]      ts_reg, ts_next;
    logic [63:0]      held_reg, held_next;
    logic             accept;
    logic [14:0]      count;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && !queue_full;
    assign count    = {s_tdata[54:48], s_tdata[63:56]};

    // Phase decoding and command assembly.
    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        ts_next    = ts_reg;
        held_next  = held_reg;
        push       = 1'b0;
        push_cmd   = '0;
        push_cmd.timestamp = ts_reg;
        push_cmd.price  = {held_reg[7:0], held_reg[15:8], held_reg[23:16], held_reg[31:24]};
        push_cmd.qty    = {held_reg[39:32], held_reg[47:40], held_reg[55:48], held_reg[63:56]};
        push_cmd.level  = {s_tdata[7:0], s_tdata[15:8]};
        push_cmd.side   = s_tdata[16];
        push_cmd.action = s_tdata[25:24];
        if (accept) begin
            unique case (phase_reg)
                PH_HDR1: begin
                    ts_next    = {s_tdata[55:48], s_tdata[63:56], 48'd0};
                    phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    ts_next = {ts_reg[63:48], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                               s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};
                    phase_next = PH_HDR3;
                end
                PH_HDR3: begin
                    if (rem_reg == '0) begin
                        push             = 1'b1;
                        push_cmd.do_emit = 1'b1;
                        phase_next       = PH_HDR0;
                    end else begin
                        phase_next = PH_DELTA_A;
                    end
                end
                PH_DELTA_A: begin
                    held_next  = s_tdata;
                    phase_next = PH_DELTA_B;
                end
                PH_DELTA_B: begin
                    push              = 1'b1;
                    push_cmd.do_delta = 1'b1;
                    rem_next          = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1)) begin
                        push_cmd.do_emit = 1'b1;
                        phase_next       = PH_HDR0;
                    end else begin
                        phase_next = PH_DELTA_A;
                    end
                end
                default: begin
                    if ({17'd0, count} > 32'(MAX_DELTAS)) begin
                        rem_next = REM_W'(MAX_DELTAS);
                    end else begin
                        rem_next = REM_W'(count);
                    end
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR0;
            rem_reg   <= '0;
            ts_reg    <= '0;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            ts_reg    <= ts_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: rtl/obfe_cmd_fifo.sv
// Short command queue between the parser and the execution side.
`timescale 1ns / 1ps
module obfe_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  obfe_pkg::cmd_t push_cmd,
    input  logic           pop,
    output obfe_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = $clog2(obfe_pkg::QUEUE_DEPTH);

    obfe_pkg::cmd_t     mem_reg [obfe_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [PTR_W:0]     fill_reg;

    assign full  = (fill_reg == (PTR_W+1)'(obfe_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rd_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push && !full) begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            if (pop && !empty) begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
        end
    end

endmodule

FILE: rtl/obfe_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module obfe_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [63:0]             dividend,
    input  logic [31:0]             divisor,
    output obfe_pkg::div_status_t   status,
    output logic [63:0]             quotient
);

    localparam int CNT_W = $clog2(obfe_pkg::DIV_STEPS);

    logic [63:0]      quo_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [33:0]      trial;

    assign trial       = {1'b0, rem_reg, quo_reg[63]} - {2'b00, dsr_reg};
    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(obfe_pkg::DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-subtract datapath.
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/obfe_back.sv
// Execution side: applies deltas to the top of book and computes the features.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module obfe_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [obfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  obfe_pkg::cmd_t                     head,
    input  logic                               empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [111:0]                       m_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DIVB = 3'd4;
    localparam logic [2:0] ST_DIVV = 3'd5;
    localparam logic [2:0] ST_DIVI = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]  state_reg;
    logic [31:0] btau_reg, vtau_reg;
    logic [31:0] bid_px_reg, bid_qty_reg, ask_px_reg, ask_qty_reg;
    logic [31:0] flow_reg, burst_reg, vol_reg, prev_mid_reg;
    logic [63:0] last_ts_reg, pkt_ts_reg;
    logic [31:0] dt_reg;
    logic [63:0] nv_reg, bprod_reg, vacc_reg;
    logic        vneg_reg, imb_neg_reg, den_zero_reg;
    logic [63:0] imb_dvd_reg;
    logic [31:0] den_reg;
    logic [15:0] imb_reg;
    logic        out_valid_reg;
    logic [111:0] out_data_reg;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    obfe_pkg::div_status_t div_st;
    logic [63:0] div_q;

    logic        load_out;
    logic [31:0] btau, vtau;
    logic [31:0] q_cur, q_new;
    logic [63:0] dt64;
    logic [32:0] px_sum;
    logic [31:0] mid;
    logic [33:0] mid_diff, mid_abs;
    logic [32:0] num, den, num_abs;
    logic [32:0] burst_up;
    logic [63:0] burst_left;
    logic [63:0] vmag, vquo, vsum;

    assign cfg_ready = 1'b1;
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign btau      = (btau_reg == '0) ? 32'd1 : btau_reg;
    assign vtau      = (vtau_reg == '0) ? 32'd1 : vtau_reg;

    // Quantity update of the addressed top-of-book side.
    always_comb begin
        q_cur = head.side ? ask_qty_reg : bid_qty_reg;
        case (head.action)
            obfe_pkg::ACT_SET:   q_new = head.qty;
            obfe_pkg::ACT_CLEAR: q_new = '0;
            default:             q_new = q_cur + head.qty;
        endcase
        if (q_new[31]) begin
            q_new = '0;
        end
    end

    // Packet time gap, mid-price change and imbalance operands.
    always_comb begin
        dt64     = (last_ts_reg == '0) ? 64'd0 : pkt_ts_reg - last_ts_reg;
        px_sum   = {bid_px_reg[31], bid_px_reg} + {ask_px_reg[31], ask_px_reg};
        mid      = px_sum[32:1];
        mid_diff = {mid[31], mid[31], mid} - {prev_mid_reg[31], prev_mid_reg[31], prev_mid_reg};
        mid_abs  = mid_diff[33] ? (34'd0 - mid_diff) : mid_diff;
        num      = {1'b0, bid_qty_reg} - {1'b0, ask_qty_reg};
        den      = {1'b0, bid_qty_reg} + {1'b0, ask_qty_reg};
        num_abs  = num[32] ? (33'd0 - num) : num;
    end

    // Burst and volatility updates from divider results.
    always_comb begin
        burst_up   = {1'b0, burst_reg} + 33'd65536;
        burst_left = {31'd0, burst_up} - div_q;
        vmag       = vacc_reg[63] ? (64'd0 - vacc_reg) : vacc_reg;
        vquo       = vneg_reg ? (64'd0 - div_q) : div_q;
        vsum       = {32'd0, vol_reg} + vquo;
    end

    // Divider operand selection.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = bprod_reg;
        div_divisor  = btau;
        unique case (state_reg)
            ST_MUL2: begin
                div_start = 1'b1;
            end
            ST_DIVB: begin
                div_start    = div_st.done;
                div_dividend = vmag;
                div_divisor  = vtau;
            end
            ST_DIVV: begin
                div_start    = div_st.done;
                div_dividend = imb_dvd_reg;
                div_divisor  = den_zero_reg ? 32'd1 : den_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    obfe_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_st),
        .quotient (div_q)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            btau_reg <= obfe_pkg::BURST_TAU_RESET;
            vtau_reg <= obfe_pkg::VOL_TAU_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == obfe_pkg::CFG_BURST_TAU) begin
                btau_reg <= cfg_data;
            end else if (cfg_index == obfe_pkg::CFG_VOL_TAU) begin
                vtau_reg <= cfg_data;
            end
        end
    end

    // Sequencer and feature state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bid_px_reg    <= '0;
            bid_qty_reg   <= '0;
            ask_px_reg    <= '0;
            ask_qty_reg   <= '0;
            flow_reg      <= '0;
            burst_reg     <= '0;
            vol_reg       <= '0;
            prev_mid_reg  <= '0;
            last_ts_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!empty) begin
                        if (head.do_delta) begin
                            // Only level zero updates the book; order flow counts adds at every level.
                            if (head.level == '0) begin
                                if (head.side) begin
                                    ask_qty_reg <= q_new;
                                    if (head.action == obfe_pkg::ACT_SET) begin
                                        ask_px_reg <= head.price;
                                    end
                                end else begin
                                    bid_qty_reg <= q_new;
                                    if (head.action == obfe_pkg::ACT_SET) begin
                                        bid_px_reg <= head.price;
                                    end
                                end
                            end
                            if (head.action == obfe_pkg::ACT_ADD_A ||
                                head.action == obfe_pkg::ACT_ADD_B) begin
                                flow_reg <= head.side ? flow_reg - head.qty
                                                      : flow_reg + head.qty;
                            end
                        end
                        if (head.do_emit) begin
                            pkt_ts_reg <= head.timestamp;
                            state_reg  <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    dt_reg       <= (dt64[63:32] != '0) ? 32'hFFFF_FFFF : dt64[31:0];
                    last_ts_reg  <= pkt_ts_reg;
                    prev_mid_reg <= mid;
                    nv_reg       <= {14'd0, mid_abs, 16'd0} - {32'd0, vol_reg};
                    imb_neg_reg  <= num[32];
                    imb_dvd_reg  <= {16'd0, num_abs, 15'd0};
                    den_reg      <= den[31:0];
                    den_zero_reg <= (den == '0);
                    state_reg    <= ST_MUL;
                end
                ST_MUL: begin
                    bprod_reg <= {32'd0, burst_reg} * {32'd0, dt_reg};
                    vacc_reg  <= {32'd0, nv_reg[31:0]} * {32'd0, dt_reg};
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    vacc_reg  <= vacc_reg + {nv_reg[63:32] * dt_reg, 32'd0};
                    state_reg <= ST_DIVB;
                end
                ST_DIVB: begin
                    if (div_st.done) begin
                        if (div_q >= {31'd0, burst_up}) begin
                            burst_reg <= '0;
                        end else if (burst_left[63:32] != '0) begin
                            burst_reg <= 32'hFFFF_FFFF;
                        end else begin
                            burst_reg <= burst_left[31:0];
                        end
                        vneg_reg  <= vacc_reg[63];
                        state_reg <= ST_DIVV;
                    end
                end
                ST_DIVV: begin
                    if (div_st.done) begin
                        if (vsum[63]) begin
                            vol_reg <= '0;
                        end else if (vsum[62:32] != '0) begin
                            vol_reg <= 32'hFFFF_FFFF;
                        end else begin
                            vol_reg <= vsum[31:0];
                        end
                        state_reg <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    if (div_st.done) begin
                        if (den_zero_reg) begin
                            imb_reg <= '0;
                        end else if (imb_neg_reg) begin
                            imb_reg <= 16'd0 - div_q[15:0];
                        end else if (div_q > 64'd32767) begin
                            imb_reg <= 16'h7FFF;
                        end else begin
                            imb_reg <= div_q[15:0];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {vol_reg, burst_reg, imb_reg, flow_reg};
        end
    end

    `OBFE_ASSERT_IMPLIES(a_start_idle, div_start, !div_st.busy)
    `OBFE_ASSERT_IMPLIES(a_pop_nonempty, pop, !empty)
    `OBFE_ASSERT_IMPLIES(a_no_overwrite, out_valid_reg && !m_tready, !load_out)

endmodule

FILE: rtl/order_book_feature_engine.sv
// Top level of the order book feature engine.
`timescale 1ns / 1ps
// Takes 64-bit packet beats on the s_ channel, up to one per cycle while the four-entry
// command queue has room, and keeps the level-zero bid and ask price and quantity plus
// the running order flow; deeper book levels reach the outputs only through the flow.
// The execution side pops each delta command while idle, so a run of deltas streams
// at one beat per cycle until packet-end work fills the queue. Each packet end yields
// one feature transaction on the m_ channel after the execution side takes it from the
// queue: a preparation step, a volatility multiply split over ST_MUL and ST_MUL2, three
// passes through the single shared restoring divider (burst decay, volatility step,
// book imbalance) and the load of the result register, which back-pressure on m_tready
// can hold off. The execution side takes its next command in the cycle after the
// result is loaded, and meanwhile the input stalls once the queue is full, so the
// packet-end work is what sets the input rate. Configuration registers: index 0 is the
// burst time constant, index 1 the volatility time constant, both in nanoseconds.
module order_book_feature_engine #(
    parameter int MAX_DELTAS = 128
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // beat_data[63:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // flow_imbalance[31:0], book_imbalance[47:32], burst_rate[79:48],
    // mid_volatility[111:80]
    output logic [111:0]                     m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [obfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    logic           push, pop, full, empty;
    obfe_pkg::cmd_t push_cmd, head;

    obfe_front #(.MAX_DELTAS(MAX_DELTAS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    obfe_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    obfe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the order book feature engine.
`timescale 1ns / 1ps
module tb_top;

    localparam int LEVELS      = 16;
    localparam int DELTA_CAP   = 128;
    localparam int SETTLE      = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;

    // One feature transaction as it leaves the block.
    typedef struct packed {
        logic [31:0] vol;
        logic [31:0] burst;
        logic [15:0] imb;
        logic [31:0] flow;
    } feat_word_t;

    // One row of the directed table: a beat and, where obvious, its result.
    typedef struct {
        logic [63:0] beat;
        bit          typed;
        feat_word_t  want;
    } beat_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [63:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [111:0]                   m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [obfe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    order_book_feature_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the block's book, flow and feature state.
    logic signed [31:0] bid_px [LEVELS];
    logic signed [31:0] bid_sz [LEVELS];
    logic signed [31:0] ask_px [LEVELS];
    logic signed [31:0] ask_sz [LEVELS];
    logic [31:0] flow_acc, burst_acc, vol_acc, mid_last, burst_tau, vol_tau;
    logic [63:0] ts_last, ts_pkt, held_beat;
    int          beat_phase, deltas_left;

    feat_word_t pending_features[$];
    int         errors;
    bit         calm;
    bit         hold_req;
    int         quiet_cycles;

    // Applies one order book delta made of its two beats.
    function automatic void apply_delta(logic [63:0] a, logic [63:0] b);
        logic [31:0] price, qty, q;
        logic [15:0] lvl;
        logic        side;
        logic [1:0]  act;
        price = {a[7:0], a[15:8], a[23:16], a[31:24]};
        qty   = {a[39:32], a[47:40], a[55:48], a[63:56]};
        lvl   = {b[7:0], b[15:8]};
        side  = b[16];
        act   = b[25:24];
        if (lvl < LEVELS) begin
            q = side ? ask_sz[lvl] : bid_sz[lvl];
            if (act == obfe_pkg::ACT_SET) begin
                if (side) ask_px[lvl] = price;
                else bid_px[lvl] = price;
                q = qty;
            end else if (act == obfe_pkg::ACT_CLEAR) begin
                q = 0;
            end else begin
                q = q + qty;
            end
            if (q[31]) q = 0;
            if (side) ask_sz[lvl] = q;
            else bid_sz[lvl] = q;
        end
        if (act == obfe_pkg::ACT_ADD_A || act == obfe_pkg::ACT_ADD_B)
            flow_acc = side ? flow_acc - qty : flow_acc + qty;
    endfunction

    // Works out the packet-end features and advances the feature state.
    function automatic feat_word_t packet_features();
        feat_word_t f;
        logic [63:0] dt, tb, tv, decay, up, prod, mag, quo, sum, dp;
        logic signed [63:0] bq, aq, num, den, imb, s, mid, diff, nv, pm;
        dt = (ts_last == 0) ? 64'd0 : ts_pkt - ts_last;
        if (dt > 64'hFFFF_FFFF) dt = 64'hFFFF_FFFF;
        tb = (burst_tau == 0) ? 64'd1 : {32'd0, burst_tau};
        tv = (vol_tau == 0) ? 64'd1 : {32'd0, vol_tau};
        ts_last = ts_pkt;

        // Top-of-book imbalance in Q1.15.
        bq = bid_sz[0];
        aq = ask_sz[0];
        num = bq - aq;
        den = bq + aq;
        imb = 0;
        if (den != 0) begin
            imb = (num * 64'sd32768) / den;
            if (imb > 64'sd32767) imb = 64'sd32767;
            if (imb < -64'sd32768) imb = -64'sd32768;
        end

        // Leaky bucket.
        decay = ({32'd0, burst_acc} * dt) / tb;
        up = {32'd0, burst_acc} + 64'd65536;
        if (decay >= up) burst_acc = 0;
        else if (up - decay > 64'hFFFF_FFFF) burst_acc = 32'hFFFF_FFFF;
        else burst_acc = 32'(up - decay);

        // Mid-price volatility average.
        s = bid_px[0];
        s = s + ask_px[0];
        mid = s >>> 1;
        pm = $signed(mid_last);
        diff = mid - pm;
        dp = diff >= 0 ? diff : -diff;
        mid_last = mid[31:0];
        nv = $signed(dp << 16) - $signed({32'd0, vol_acc});
        prod = nv * dt;
        mag = prod[63] ? -prod : prod;
        quo = mag / tv;
        if (prod[63]) quo = -quo;
        sum = {32'd0, vol_acc} + quo;
        if (sum[63]) vol_acc = 0;
        else if (sum > 64'hFFFF_FFFF) vol_acc = 32'hFFFF_FFFF;
        else vol_acc = sum[31:0];

        f.flow  = flow_acc;
        f.imb   = imb[15:0];
        f.burst = burst_acc;
        f.vol   = vol_acc;
        return f;
    endfunction

    // Advances the packet parser by one beat; returns 1 when a result is due.
    function automatic bit absorb_beat(logic [63:0] w, output feat_word_t f);
        int n;
        f = '0;
        case (beat_phase)
            1: begin
                ts_pkt = {w[55:48], w[63:56], 48'd0};
                beat_phase = 2;
            end
            2: begin
                ts_pkt[47:0] = {w[7:0], w[15:8], w[23:16], w[31:24], w[39:32], w[47:40]};
                beat_phase = 3;
            end
            3: begin
                if (deltas_left == 0) begin
                    beat_phase = 0;
                    f = packet_features();
                    return 1;
                end
                beat_phase = 4;
            end
            4: begin
                held_beat = w;
                beat_phase = 5;
            end
            5: begin
                apply_delta(held_beat, w);
                deltas_left--;
                if (deltas_left == 0) begin
                    beat_phase = 0;
                    f = packet_features();
                    return 1;
                end
                beat_phase = 4;
            end
            default: begin
                n = {w[55:48], w[63:56]} & 16'h7FFF;
                deltas_left = n > DELTA_CAP ? DELTA_CAP : n;
                beat_phase = 1;
            end
        endcase
        return 0;
    endfunction

    // Beat builders; bytes not carrying a field are random.
    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] hdr_count(logic [15:0] count);
        logic [63:0] w;
        w = rnd64();
        w[55:48] = count[15:8];
        w[63:56] = count[7:0];
        return w;
    endfunction

    function automatic logic [63:0] hdr_ts_hi(logic [63:0] ts);
        logic [63:0] w;
        w = rnd64();
        w[55:48] = ts[63:56];
        w[63:56] = ts[55:48];
        return w;
    endfunction

    function automatic logic [63:0] hdr_ts_lo(logic [63:0] ts);
        logic [63:0] w;
        w = rnd64();
        w[47:0] = {ts[7:0], ts[15:8], ts[23:16], ts[31:24], ts[39:32], ts[47:40]};
        return w;
    endfunction

    function automatic logic [63:0] delta_px_qty(logic [31:0] price, logic [31:0] qty);
        return {qty[7:0], qty[15:8], qty[23:16], qty[31:24],
                price[7:0], price[15:8], price[23:16], price[31:24]};
    endfunction

    function automatic logic [63:0] delta_where(logic [15:0] lvl, logic side, logic [1:0] act);
        logic [63:0] w;
        w = rnd64();
        w[15:0]  = {lvl[7:0], lvl[15:8]};
        w[16]    = side;
        w[25:24] = act;
        return w;
    endfunction

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Sends one beat and updates the prediction once it is taken.
    task automatic send_beat(logic [63:0] w, bit typed = 0, feat_word_t want = '0);
        feat_word_t f;
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        if (absorb_beat(w, f)) pending_features.push_back(typed ? want : f);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Waits until the block has drained, then lets its tail cycles pass.
    task automatic drain();
        while (pending_features.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes one configuration register while the block is idle.
    task automatic write_reg(logic [obfe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == obfe_pkg::CFG_BURST_TAU) burst_tau = value;
        else vol_tau = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one random packet; mostly few deltas near level zero.
    task automatic send_packet(inout logic [63:0] ts_clock, output int beats);
        logic [15:0] count;
        logic [63:0] ts;
        logic [31:0] price, qty;
        logic [15:0] lvl;
        int          n, r;
        r = $urandom_range(99);
        if (r < 3) count = 16'($urandom);
        else if (r < 6) count = 16'(DELTA_CAP + $urandom_range(0, 3));
        else count = 16'($urandom_range(0, 6) | ($urandom_range(1) << 15));
        n = (count & 16'h7FFF) > DELTA_CAP ? DELTA_CAP : (count & 16'h7FFF);
        beats = 4 + 2 * n;
        r = $urandom_range(99);
        if (r < 4) ts = rnd64();
        else if (r < 7) ts = 0;
        else if (r < 10) ts = ts_clock - $urandom_range(1, 1000);
        else begin
            ts_clock = ts_clock + $urandom_range(0, 400000);
            ts = ts_clock;
        end
        send_beat(hdr_count(count));
        send_beat(hdr_ts_hi(ts));
        send_beat(hdr_ts_lo(ts));
        send_beat(rnd64());
        repeat (n) begin
            r = $urandom_range(99);
            price = (r < 85) ? 32'd100000 + $urandom_range(0, 400) : $urandom;
            r = $urandom_range(99);
            if (r < 70) qty = $urandom_range(0, 5000);
            else if (r < 85) qty = -$urandom_range(1, 5000);
            else qty = $urandom;
            r = $urandom_range(99);
            if (r < 60) lvl = 0;
            else if (r < 85) lvl = 16'($urandom_range(1, LEVELS - 1));
            else lvl = 16'($urandom);
            send_beat(delta_px_qty(price, qty));
            send_beat(delta_where(lvl, 1'($urandom_range(1)), 2'($urandom_range(3))));
        end
    endtask

    // Receiver: random back-pressure, a long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 29);
            end
        end
    end

    // Result checker and stall watchdog.
    always @(posedge aclk) begin
        feat_word_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_features.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    want = pending_features.pop_front();
                    if (got.flow !== want.flow) begin
                        $error("flow_imbalance: expected %0d, got %0d",
                               $signed(want.flow), $signed(got.flow));
                        errors++;
                    end
                    if (got.imb !== want.imb) begin
                        $error("book_imbalance: expected %0d, got %0d",
                               $signed(want.imb), $signed(got.imb));
                        errors++;
                    end
                    if (got.burst !== want.burst) begin
                        $error("burst_rate: expected %0d, got %0d", want.burst, got.burst);
                        errors++;
                    end
                    if (got.vol !== want.vol) begin
                        $error("mid_volatility: expected %0d, got %0d", want.vol, got.vol);
                        errors++;
                    end
                end
            end
        end
    end

    // Stimulus.
    initial begin
        beat_row_t   rows[$];
        feat_word_t  first_want;
        logic [63:0] ts_clock;
        int          sent_phase;
        int          pkt_beats;

        errors = 0;
        calm = 0;
        hold_req = 0;
        quiet_cycles = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < LEVELS; i++) begin
            bid_px[i] = 0; bid_sz[i] = 0; ask_px[i] = 0; ask_sz[i] = 0;
        end
        flow_acc = 0; burst_acc = 0; vol_acc = 0; mid_last = 0;
        ts_last = 0; ts_pkt = 0; held_beat = 0;
        beat_phase = 0; deltas_left = 0;
        burst_tau = obfe_pkg::BURST_TAU_RESET;
        vol_tau = obfe_pkg::VOL_TAU_RESET;

        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty first packet: zero gap, empty book, one bucket unit.
        first_want = '{vol: 32'd0, burst: 32'd65536, imb: 16'd0, flow: 32'd0};
        rows.push_back('{hdr_count(16'd0), 0, '0});
        rows.push_back('{hdr_ts_hi(64'd1000), 0, '0});
        rows.push_back('{hdr_ts_lo(64'd1000), 0, '0});
        rows.push_back('{rnd64(), 1, first_want});
        // Set both sides at level zero with extreme prices and sizes.
        rows.push_back('{hdr_count(16'h8002), 0, '0});
        rows.push_back('{hdr_ts_hi(64'hFFFF_0000_0000_2000), 0, '0});
        rows.push_back('{hdr_ts_lo(64'hFFFF_0000_0000_2000), 0, '0});
        rows.push_back('{rnd64(), 0, '0});
        rows.push_back('{delta_px_qty(32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, '0});
        rows.push_back('{delta_where(16'd0, 1'b0, obfe_pkg::ACT_SET), 0, '0});
        rows.push_back('{delta_px_qty(32'h8000_0000, 32'd1), 0, '0});
        rows.push_back('{delta_where(16'd0, 1'b1, obfe_pkg::ACT_SET), 0, '0});
        // Adds, a negative size clamped, a clear and an out-of-range level.
        rows.push_back('{hdr_count(16'd3), 0, '0});
        rows.push_back('{hdr_ts_hi(64'd3000), 0, '0});
        rows.push_back('{hdr_ts_lo(64'd3000), 0, '0});
        rows.push_back('{rnd64(), 0, '0});
        rows.push_back('{delta_px_qty(32'hFFFF_FFFF, 32'd500), 0, '0});
        rows.push_back('{delta_where(16'hFFFF, 1'b0, obfe_pkg::ACT_ADD_A), 0, '0});
        rows.push_back('{delta_px_qty(32'd0, 32'h8000_0000), 0, '0});
        rows.push_back('{delta_where(16'd0, 1'b1, obfe_pkg::ACT_ADD_B), 0, '0});
        rows.push_back('{delta_px_qty(32'd0, 32'd0), 0, '0});
        rows.push_back('{delta_where(16'd15, 1'b0, obfe_pkg::ACT_CLEAR), 0, '0});
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].want);
        stop_sending();

        // Random phases, each under its own pair of time constants.
        ts_clock = 64'd10000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(obfe_pkg::CFG_BURST_TAU, 32'd1);
                    write_reg(obfe_pkg::CFG_VOL_TAU, 32'd1);
                end
                2: begin
                    write_reg(obfe_pkg::CFG_BURST_TAU, 32'hFFFF_FFFF);
                    write_reg(obfe_pkg::CFG_VOL_TAU, 32'hFFFF_FFFF);
                end
                3: begin
                    write_reg(obfe_pkg::CFG_BURST_TAU, 32'd0);
                    write_reg(obfe_pkg::CFG_VOL_TAU, 32'd0);
                end
                default: begin
                    write_reg(obfe_pkg::CFG_BURST_TAU, $urandom_range(1, 1000000));
                    write_reg(obfe_pkg::CFG_VOL_TAU, $urandom_range(1, 10000000));
                end
            endcase
            if (ph == 1) hold_req = 1;
            calm = (ph == 4);
            sent_phase = 0;
            while (sent_phase < 235) begin
                send_packet(ts_clock, pkt_beats);
                sent_phase += pkt_beats;
                // Sender waits for every result now and then.
                if ($urandom_range(9) == 0) begin
                    stop_sending();
                    while (pending_features.size() != 0) @(posedge aclk);
                end
            end
            stop_sending();
        end
        calm = 0;

        drain();
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
